// File: src/stks_pkg.sv
`default_nettype none

package stks_pkg;

   // Fixed field widths of the request and response items
   localparam int POS_W     = 10;
   localparam int IN_KEY_W  = 32;
   localparam int FUNC_W    = 2;

   // Defaults for the top-level parameters
   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int KEY_WIDTH_DEFAULT   = 32;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LINEAR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_BINARY = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;      // request transfer this cycle
      logic lin_step;    // issue one linear-scan read and step the pointer
      logic bin_read;    // issue the midpoint read of a halving step
      logic bin_update;  // narrow the interval after a midpoint compare
      logic res_lin;     // record linear-scan hit
      logic res_bin;     // record binary-search hit
      logic load_out;    // move the result into the response register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [FUNC_W-1:0] op;  // operation of the offered request
      logic lin_hit;          // compared entry matches the key
      logic lin_end;          // scan pipeline drained without a hit
      logic bin_empty;        // interval is empty
      logic bin_eq;           // midpoint entry equals the key
   } status_type;

endpackage

`default_nettype wire

// File: src/stks_req_if.sv
`default_nettype none

interface stks_req_if;
   logic                               valid;
   logic                               ready;
   logic [stks_pkg::FUNC_W-1:0]        func;
   logic [stks_pkg::POS_W-1:0]         position;
   logic [stks_pkg::IN_KEY_W-1:0]      key;

   modport source (output valid, output func, output position, output key, input ready);
   modport sink   (input valid, input func, input position, input key, output ready);
endinterface

`default_nettype wire

// File: src/stks_rsp_if.sv
`default_nettype none

interface stks_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [stks_pkg::POS_W-1:0]    match_position;

   modport source (output valid, output found, output match_position, input ready);
   modport sink   (input valid, input found, input match_position, output ready);
endinterface

`default_nettype wire

// File: src/sorted_table_key_search.sv
// Sorted table key search.
// Request channel (req_chan): func, position, key. func selects a table write,
// a linear scan from the top position down, or a binary search over [1, size].
// Response channel (rsp_chan): found and match_position, one per request;
// match_position is 0 with found clear on a miss, a write or an unused code.
// csr_wr_en/csr_wr_data write the size in use; sizes past the table saturate.
// One request is worked at a time; the next transfer is taken the cycle after
// the result moves to the response register.
// A write or an unused code needs no table read; a linear scan reads one table
// entry a cycle from the top position down and compares in the cycle after
// each read; a binary search halves the interval in steps of a registered
// memory read at the midpoint, then a compare; the size in use saturates to
// the table.
// Reset clears the size to 0 and the control state; table contents are
// undefined until written.
// If the receiver stalls, the finished response waits in the response
// register; the following request is still worked and then waits for it.

`default_nettype none

module sorted_table_key_search #(
   parameter int TABLE_DEPTH = stks_pkg::TABLE_DEPTH_DEFAULT,
   parameter int KEY_WIDTH   = stks_pkg::KEY_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   stks_req_if.sink                           req_chan,
   stks_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [stks_pkg::POS_W-1:0]    csr_wr_data
);

   stks_pkg::cmd_type    cmd;
   stks_pkg::status_type status;

   // Sequencer
   stks_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Table, search registers and response payload
   stks_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_func           (req_chan.func),
      .req_position       (req_chan.position),
      .req_key            (req_chan.key),
      .cmd                (cmd),
      .status             (status),
      .rsp_found          (rsp_chan.found),
      .rsp_match_position (rsp_chan.match_position)
   );

endmodule

`default_nettype wire

// File: src/stks_datapath.sv
`default_nettype none

module stks_datapath #(
   parameter int TABLE_DEPTH = stks_pkg::TABLE_DEPTH_DEFAULT,
   parameter int KEY_WIDTH   = stks_pkg::KEY_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [stks_pkg::POS_W-1:0]        csr_wr_data,
   input  wire logic [stks_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [stks_pkg::POS_W-1:0]        req_position,
   input  wire logic [stks_pkg::IN_KEY_W-1:0]     req_key,
   input  wire stks_pkg::cmd_type                 cmd,
   output stks_pkg::status_type                   status,
   output logic                                   rsp_found,
   output logic [stks_pkg::POS_W-1:0]             rsp_match_position
);

   localparam int POS_W  = stks_pkg::POS_W;
   localparam int BND_W  = POS_W + 1;     // interval bounds may pass the top by one
   localparam int SUM_W  = POS_W + 2;
   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   // Table memory
   logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];

   logic [POS_W-1:0]     size_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] rdata_ff;
   logic [POS_W-1:0]     ptr_ff,     ptr_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [POS_W-1:0]     cmp_pos_ff;
   logic [BND_W-1:0]     lo_ff,      lo_in;
   logic [BND_W-1:0]     hi_ff,      hi_in;
   logic [POS_W-1:0]     mid_ff;
   logic                 res_found_ff, res_found_in;
   logic [POS_W-1:0]     res_pos_ff,   res_pos_in;

   logic [POS_W-1:0]     top_w;
   logic [SUM_W-1:0]     sum_w;
   logic [POS_W-1:0]     mid_w;
   logic [ADDR_W-1:0]    rd_addr_w;
   logic                 wr_en_w;
   logic                 bin_lt_w;

   // Highest searchable position, saturated to the table
   assign top_w = (32'(size_ff) >= TABLE_DEPTH) ? POS_W'(TABLE_DEPTH - 1) : size_ff;

   // Floor midpoint; never above the top, so it fits a position
   assign sum_w = SUM_W'(lo_ff) + SUM_W'(hi_ff);
   assign mid_w = sum_w[POS_W:1];

   assign rd_addr_w = cmd.bin_read ? ADDR_W'(mid_w) : ADDR_W'(ptr_ff);
   assign wr_en_w   = cmd.accept && (req_func == stks_pkg::FUNC_WRITE) &&
                      (32'(req_position) < TABLE_DEPTH);

   // Memory: write on a write transfer, registered read every cycle
   always_ff @(posedge clock) begin
      if (wr_en_w) begin
         mem[ADDR_W'(req_position)] <= KEY_WIDTH'(req_key);
      end
      rdata_ff <= mem[rd_addr_w];
   end

   // Size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   assign bin_lt_w = rdata_ff < key_ff;

   // Status back to the controller
   always_comb begin
      status.op        = req_func;
      status.lin_hit   = cmp_vld_ff && (rdata_ff == key_ff);
      status.lin_end   = (ptr_ff == '0) && !cmp_vld_ff;
      status.bin_empty = lo_ff > hi_ff;
      status.bin_eq    = rdata_ff == key_ff;
   end

   // Search state next values
   always_comb begin
      ptr_in       = ptr_ff;
      cmp_vld_in   = 1'b0;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      if (cmd.accept) begin
         ptr_in       = top_w;
         lo_in        = BND_W'(1);
         hi_in        = BND_W'(top_w);
         res_found_in = 1'b0;
         res_pos_in   = '0;
      end
      // scan one entry a cycle; the compare works on the registered read data
      if (cmd.lin_step) begin
         cmp_vld_in = ptr_ff != '0;
         if (ptr_ff != '0) begin
            ptr_in = ptr_ff - POS_W'(1);
         end
      end
      if (cmd.bin_update && !status.bin_eq) begin
         if (bin_lt_w) begin
            lo_in = BND_W'(mid_ff) + BND_W'(1);
         end else begin
            hi_in = BND_W'(mid_ff) - BND_W'(1);
         end
      end
      if (cmd.res_lin) begin
         res_found_in = 1'b1;
         res_pos_in   = cmp_pos_ff;
      end
      if (cmd.res_bin) begin
         res_found_in = 1'b1;
         res_pos_in   = mid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff <= KEY_WIDTH'(req_key);
      end
      if (cmd.lin_step) begin
         cmp_pos_ff <= ptr_ff;
      end
      if (cmd.bin_read) begin
         mid_ff <= mid_w;
      end
      ptr_ff       <= ptr_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      if (cmd.load_out) begin
         rsp_found          <= res_found_ff;
         rsp_match_position <= res_pos_ff;
      end
   end

   // A compare in flight always refers to a real table position
   a_cmp_pos_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (cmp_pos_ff != '0))
      else $error("scan compare at position zero");

   // A midpoint read stays inside [1, top]
   a_mid_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.bin_read |-> ((mid_w != '0) && (mid_w <= top_w)))
      else $error("binary midpoint out of range");

   // A scan hit is recorded only from a live compare
   a_res_lin_live: assert property (@(posedge clock) disable iff (reset)
      cmd.res_lin |-> cmp_vld_ff)
      else $error("scan hit without compare");

endmodule

`default_nettype wire

// File: src/stks_controller.sv
`default_nettype none

module stks_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire stks_pkg::status_type  status,
   output stks_pkg::cmd_type          cmd
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_LIN     = 5'b00010,
      ST_BIN_RD  = 5'b00100,
      ST_BIN_CMP = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = out_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.op == stks_pkg::FUNC_LINEAR) begin
                  state_in = ST_LIN;
               end else if (status.op == stks_pkg::FUNC_BINARY) begin
                  state_in = ST_BIN_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_LIN: begin
            if (status.lin_hit) begin
               cmd.res_lin = 1'b1;
               state_in    = ST_DONE;
            end else if (status.lin_end) begin
               state_in = ST_DONE;
            end else begin
               cmd.lin_step = 1'b1;
            end
         end
         ST_BIN_RD: begin
            if (status.bin_empty) begin
               state_in = ST_DONE;
            end else begin
               cmd.bin_read = 1'b1;
               state_in     = ST_BIN_CMP;
            end
         end
         ST_BIN_CMP: begin
            if (status.bin_eq) begin
               cmd.res_bin = 1'b1;
               state_in    = ST_DONE;
            end else begin
               cmd.bin_update = 1'b1;
               state_in       = ST_BIN_RD;
            end
         end
         ST_DONE: begin
            // wait here only while the previous response is still unclaimed
            if (!out_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid
   always_comb begin
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // The response register is overwritten only when free or being drained
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_valid_ff || rsp_ready))
      else $error("response overwritten while stalled");

   // A request transfer always starts work
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("request transfer without work");

   // Every finished item produces a valid response next cycle
   a_load_gives_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("loaded response not valid");

endmodule

`default_nettype wire

// File: dv/key_search_checker.sv
module key_search_checker
   import stks_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   stks_req_if                     req_mon,
   stks_rsp_if                     rsp_mon,
   input  wire logic               csr_wr_en,
   input  wire logic [POS_W-1:0]   csr_wr_data,
   output int                      outstanding,
   output int                      mismatches,
   output int                      hit_total,
   output int                      result_total
);

   localparam int DEPTH = TABLE_DEPTH_DEFAULT;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] match_position;
   } lookup_outcome_type;

   // Own copy of the table and the size register
   logic [IN_KEY_W-1:0] table_keys [DEPTH];
   logic [POS_W-1:0]    table_size;

   lookup_outcome_type pending_lookups [$];
   lookup_outcome_type want;
   lookup_outcome_type got;

   int bad_fields   = 0;
   int hits_seen    = 0;
   int results_seen = 0;

   assign mismatches   = bad_fields;
   assign hit_total    = hits_seen;
   assign result_total = results_seen;

   // Highest searchable position; sizes past the table saturate
   function automatic int top_entry();
      return (int'(table_size) > DEPTH - 1) ? DEPTH - 1 : int'(table_size);
   endfunction

   // Scan from the top entry down, highest matching position wins
   function automatic int scan_down_for(input logic [IN_KEY_W-1:0] k);
      int p;
      for (p = top_entry(); p >= 1; p--) begin
         if (table_keys[p] === k) return p;
      end
      return 0;
   endfunction

   // Halving search over [1, size], floor midpoint, first equal midpoint wins
   function automatic int halve_for(input logic [IN_KEY_W-1:0] k);
      int lo;
      int hi;
      int mid;
      lo = 1;
      hi = top_entry();
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (table_keys[mid] < k) lo = mid + 1;
         else if (table_keys[mid] > k) hi = mid - 1;
         else return mid;
      end
      return 0;
   endfunction

   // Applies one request to the table copy and returns the response it earns
   function automatic lookup_outcome_type lookup_outcome(input logic [FUNC_W-1:0] f,
                                                         input logic [POS_W-1:0] p,
                                                         input logic [IN_KEY_W-1:0] k);
      int hit;
      lookup_outcome_type r;
      hit = 0;
      case (f)
         FUNC_WRITE: begin
            if (int'(p) < DEPTH) table_keys[p] = k;
         end
         FUNC_LINEAR: hit = scan_down_for(k);
         FUNC_BINARY: hit = halve_for(k);
         default: ;
      endcase
      r.found          = (hit != 0);
      r.match_position = hit[POS_W-1:0];
      return r;
   endfunction

   // Watch config, request and response transfers
   always @(posedge clock) begin
      if (reset) begin
         pending_lookups.delete();
         table_size  <= '0;
         outstanding <= 0;
      end else begin
         if (csr_wr_en) table_size <= csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            pending_lookups.push_back(lookup_outcome(req_mon.func, req_mon.position,
                                                     req_mon.key));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.found          = rsp_mon.found;
            got.match_position = rsp_mon.match_position;
            results_seen++;
            if (got.found === 1'b1) hits_seen++;
            if (pending_lookups.size() == 0) begin
               $error("response with no request waiting: found %0d, match_position %0d",
                      got.found, got.match_position);
               bad_fields++;
            end else begin
               want = pending_lookups.pop_front();
               if (got.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, got.found);
                  bad_fields++;
               end
               if (got.match_position !== want.match_position) begin
                  $error("match_position: expected %0d, actual %0d",
                         want.match_position, got.match_position);
                  bad_fields++;
               end
            end
         end
         outstanding <= pending_lookups.size();
      end
   end

endmodule

// File: dv/testbench.sv
module testbench;
   import stks_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int DEPTH          = TABLE_DEPTH_DEFAULT;
   localparam int FILL_TOP       = 255;
   localparam int STALL_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASES         = 14;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic             csr_wr_en;
   logic [POS_W-1:0] csr_wr_data;

   stks_req_if req_chan ();
   stks_rsp_if rsp_chan ();

   int outstanding;
   int mismatches;
   int hit_total;
   int result_total;

   int send_gap_pct = 30;
   int recv_gap_pct = 49;
   int stall_ticket = 0;
   int stall_served = 0;
   int stall_left   = 0;
   int quiet_cycles = 0;

   // Table contents as written, used to aim searches at stored keys
   logic [IN_KEY_W-1:0] shadow_keys [DEPTH];

   int n_write  = 0;
   int n_linear = 0;
   int n_binary = 0;
   int n_unused = 0;
   int n_sizes  = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sorted_table_key_search DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   key_search_checker lookup_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .outstanding  (outstanding),
      .mismatches   (mismatches),
      .hit_total    (hit_total),
      .result_total (result_total)
   );

   // Response side: random backpressure, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= 0;
      end else if (stall_ticket != stall_served) begin
         stall_served   <= stall_ticket;
         stall_left     <= STALL_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left     <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_gaps(input int send_pct, input int recv_pct);
      send_gap_pct = send_pct;
      recv_gap_pct <= recv_pct;
   endtask

   // Offer one request and hold it until the transfer
   task automatic send_item(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                            input logic [IN_KEY_W-1:0] k);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.func     <= f;
      req_chan.position <= p;
      req_chan.key      <= k;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      case (f)
         FUNC_WRITE: begin
            shadow_keys[p] = k;
            n_write++;
         end
         FUNC_LINEAR: n_linear++;
         FUNC_BINARY: n_binary++;
         default:     n_unused++;
      endcase
   endtask

   // Stop offering and wait for every response
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_size(input logic [POS_W-1:0] s);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= s;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      n_sizes++;
   endtask

   // Rewrite positions 1..size: ascending, ascending with repeats, or a small pool
   task automatic load_table(input int size);
      int arrangement;
      int p;
      logic [IN_KEY_W-1:0] k;
      logic [IN_KEY_W-1:0] pool [4];
      arrangement = $urandom_range(2);
      k = $urandom_range(1) ? '0 : $urandom_range(32'h3FFF_FFFF);
      pool = '{32'd0, 32'hFFFF_FFFF, $urandom, $urandom};
      for (p = 1; p <= size; p++) begin
         case (arrangement)
            0: k = k + $urandom_range(1, 1 << 20);
            1: k = k + (($urandom_range(2) == 0) ? 0 : $urandom_range(1, 1 << 20));
            default: k = pool[$urandom_range(3)];
         endcase
         if (arrangement != 2 && p == size && $urandom_range(1)) k = 32'hFFFF_FFFF;
         send_item(FUNC_WRITE, p[POS_W-1:0], k);
      end
   endtask

   // Mostly searches aimed at stored keys, with stray writes and unused codes
   task automatic random_item(input int size);
      int pick;
      int slot;
      logic [FUNC_W-1:0]   f;
      logic [POS_W-1:0]    p;
      logic [IN_KEY_W-1:0] k;
      pick = $urandom_range(99);
      p    = POS_W'($urandom_range(DEPTH - 1));
      k    = $urandom;
      slot = (size > 0) ? $urandom_range(1, size) : 0;
      if (pick < 10) begin
         f = FUNC_WRITE;
         if (size > 0 && pick < 6) p = slot[POS_W-1:0];
      end else if (pick < 14) begin
         f = FUNC_UNUSED;
      end else begin
         f = pick[0] ? FUNC_LINEAR : FUNC_BINARY;
         if (size > 0 && pick < 70) k = shadow_keys[slot];
         else if (size > 0 && pick < 85)
            k = shadow_keys[slot] + ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
      end
      send_item(f, p, k);
   endtask

   initial begin
      int p;
      int phase;
      int size;
      int i;
      req_chan.valid    <= 1'b0;
      req_chan.func     <= FUNC_WRITE;
      req_chan.position <= '0;
      req_chan.key      <= '0;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty table after reset: searches miss, unused code, writes at both ends
      send_item(FUNC_LINEAR, 10'd0, 32'd0);
      send_item(FUNC_BINARY, 10'h3FF, 32'hFFFF_FFFF);
      send_item(FUNC_UNUSED, 10'h3FF, 32'hFFFF_FFFF);
      send_item(FUNC_WRITE, 10'd0, 32'd0);
      send_item(FUNC_WRITE, 10'h3FF, 32'hFFFF_FFFF);
      send_item(FUNC_LINEAR, 10'h155, 32'd0);
      send_item(FUNC_BINARY, 10'h2AA, 32'd0);

      // Fill the low part of the table in ascending order so every size used is safe
      for (p = 1; p <= FILL_TOP; p++)
         send_item(FUNC_WRITE, p[POS_W-1:0],
                   (p == FILL_TOP) ? 32'hFFFF_FFFF : {p[9:0], 22'($urandom)});

      // Largest size used: long scans and deepest halving
      set_size(POS_W'(FILL_TOP));
      send_item(FUNC_LINEAR, 10'd0, shadow_keys[1]);
      send_item(FUNC_LINEAR, 10'd0, 32'hFFFF_FFFF);
      send_item(FUNC_BINARY, 10'd0, shadow_keys[1]);
      send_item(FUNC_BINARY, 10'd0, 32'hFFFF_FFFF);
      send_item(FUNC_BINARY, 10'd0, shadow_keys[128]);
      send_item(FUNC_BINARY, 10'd0, 32'd1);
      send_item(FUNC_LINEAR, 10'd0, 32'd1);

      // Single entry; entry 2 is out of reach
      set_size(10'd1);
      send_item(FUNC_BINARY, 10'd0, shadow_keys[1]);
      send_item(FUNC_LINEAR, 10'd0, shadow_keys[1]);
      send_item(FUNC_BINARY, 10'd0, shadow_keys[2]);

      // Repeated key: the scan returns the higher copy, halving runs unsorted
      set_size(10'd4);
      send_item(FUNC_WRITE, 10'd2, 32'h0000_BEEF);
      send_item(FUNC_WRITE, 10'd4, 32'h0000_BEEF);
      send_item(FUNC_LINEAR, 10'd0, 32'h0000_BEEF);
      send_item(FUNC_BINARY, 10'd0, 32'h0000_BEEF);

      // Random phases, each with its own size and table layout
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 5) set_gaps(49, 30);
         else if (phase == 10) set_gaps(0, 0);
         if (phase == 0) size = 0;
         else if (phase % 5 == 3) size = FILL_TOP;
         else size = $urandom_range(1, 24);
         set_size(size[POS_W-1:0]);
         if (size > 0 && size <= 64) load_table(size);
         // long receiver hold-off while requests keep coming
         if (phase == 1) stall_ticket <= stall_ticket + 1;
         for (i = 0; i < ((size == FILL_TOP) ? 10 : 18); i++) random_item(size);
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Covered %0d writes, %0d linear and %0d binary searches, %0d unused codes, %0d sizes.",
               n_write, n_linear, n_binary, n_unused, n_sizes);
      $display("%0d responses compared, %0d of them hits, %0d field mismatches.",
               result_total, hit_total, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
